@@ src/grs_pkg.sv @@
// ----------------------------------------------------------------------------
// grs_pkg
// shared types and constants for the group reversing stream block
// ----------------------------------------------------------------------------
package grs_pkg;

	// defaults for the top-level parameters
	localparam int MAX_GROUP_DEF   = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	// group size register
	localparam int                  CFG_WIDTH        = 5;
	localparam logic [CFG_WIDTH-1:0] GROUP_SIZE_RESET = CFG_WIDTH'(2);

	// sequencer states, one-hot
	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	// one buffer read issued by the sequencer, with the flags of its result
	typedef struct packed {
		logic valid;
		logic fin;
		logic seq_end;
	} rd_issue_t;

	// flags that travel alongside the read data
	typedef struct packed {
		logic fin;
		logic seq_end;
	} rd_tag_t;

endpackage

@@ src/grs_mem.sv @@
// ----------------------------------------------------------------------------
// grs_mem
// group buffer: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module grs_mem #(
	parameter int DEPTH = grs_pkg::MAX_GROUP_DEF,
	parameter int WIDTH = grs_pkg::VALUE_WIDTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ src/grs_ctrl.sv @@
// ----------------------------------------------------------------------------
// grs_ctrl
// fill counter and drain sequencer: writes arriving values, then reads a
// finished group back reversed, or a short final group in arrival order
// ----------------------------------------------------------------------------
module grs_ctrl #(
	parameter int MAX_GROUP = grs_pkg::MAX_GROUP_DEF,
	parameter int AW        = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           seq_last,
	input  logic [grs_pkg::CFG_WIDTH-1:0]  group_size,
	input  logic                           can_issue,
	output logic                           wr_en,
	output logic [AW-1:0]                  wr_addr,
	output logic                           rd_en,
	output logic [AW-1:0]                  rd_addr,
	output grs_pkg::rd_issue_t             issue
);

	import grs_pkg::*;

	localparam int CW = $clog2(MAX_GROUP + 1);
	localparam int KW = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;

	state_t        state_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] addr_q;
	logic          rev_q;
	logic          end_q;

	logic          accept;
	logic [CW-1:0] n;
	logic [KW-1:0] gs_ext;
	logic [KW-1:0] k_eff;
	logic          group_full;
	logic          do_issue;
	logic          fin;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q == ST_DRAIN);
	assign n = fill_q + CW'(1);

	// zero acts as one, sizes above the buffer depth saturate
	assign gs_ext = KW'(group_size);
	always_comb begin
		priority if (gs_ext == '0) begin
			k_eff = KW'(1);
		end else if (gs_ext > KW'(MAX_GROUP)) begin
			k_eff = KW'(MAX_GROUP);
		end else begin
			k_eff = gs_ext;
		end
	end
	assign group_full = (KW'(n) >= k_eff);

	assign wr_en = accept;
	assign wr_addr = fill_q[AW-1:0];

	assign do_issue = (state_q == ST_DRAIN) && can_issue;
	assign fin = (cnt_q == CW'(1));
	assign rd_en = do_issue;
	assign rd_addr = addr_q;
	assign issue.valid = do_issue;
	assign issue.fin = fin;
	assign issue.seq_end = fin && end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			cnt_q <= '0;
			addr_q <= '0;
			rev_q <= 1'b0;
			end_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (group_full) begin
							// newest first: start at the entry just written
							state_q <= ST_DRAIN;
							addr_q <= fill_q[AW-1:0];
							rev_q <= 1'b1;
							cnt_q <= n;
							end_q <= seq_last;
							fill_q <= '0;
						end else if (seq_last) begin
							state_q <= ST_DRAIN;
							addr_q <= '0;
							rev_q <= 1'b0;
							cnt_q <= n;
							end_q <= 1'b1;
							fill_q <= '0;
						end else begin
							fill_q <= n;
						end
					end
				end
				ST_DRAIN: begin
					if (do_issue) begin
						addr_q <= rev_q ? (addr_q - AW'(1)) : (addr_q + AW'(1));
						cnt_q <= cnt_q - CW'(1);
						if (fin) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_drain_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (cnt_q != '0))
		else $error("drain with nothing left to read");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < CW'(MAX_GROUP))
		else $error("fill count reached buffer depth");

	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && group_full) |=> (state_q == ST_DRAIN) && (cnt_q == $past(n)) && rev_q)
		else $error("full group did not start a reversed drain");

	a_fill_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (group_full || seq_last)) |=> (fill_q == '0))
		else $error("fill count not cleared after drain start");

endmodule

@@ src/grs_outq.sv @@
// ----------------------------------------------------------------------------
// grs_outq
// read stage and output register; gives the sequencer credit to read
// ----------------------------------------------------------------------------
module grs_outq #(
	parameter int WIDTH = grs_pkg::VALUE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  grs_pkg::rd_issue_t issue,
	output logic               can_issue,
	input  logic [WIDTH-1:0]   rd_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [WIDTH-1:0]   value_out,
	output logic               out_last,
	output logic               seq_end
);

	import grs_pkg::*;

	logic             s1_valid_q;
	rd_tag_t          s1_tag_q;
	logic             out_valid_q;
	logic [WIDTH-1:0] value_q;
	rd_tag_t          out_tag_q;
	logic             advance;

	// output register free or emptied this cycle
	assign advance = !out_valid_q || !out_stall;
	assign can_issue = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue.valid) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue.valid) begin
			s1_tag_q.fin <= issue.fin;
			s1_tag_q.seq_end <= issue.seq_end;
		end
		if (advance && s1_valid_q) begin
			value_q <= rd_data;
			out_tag_q <= s1_tag_q;
		end
	end

	assign out_valid = out_valid_q;
	assign value_out = value_q;
	assign out_last = out_tag_q.fin;
	assign seq_end = out_tag_q.seq_end;

	a_issue_credit: assert property (@(posedge clk) disable iff (!arst_n)
		issue.valid |-> can_issue)
		else $error("read issued without room in the read stage");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !advance) |=> s1_valid_q && $stable(s1_tag_q))
		else $error("read stage lost data while output stalled");

	a_seq_end_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_tag_q.seq_end) |-> out_tag_q.fin)
		else $error("sequence end without step end");

endmodule

@@ src/group_reverse_stream.sv @@
// ----------------------------------------------------------------------------
// group_reverse_stream
// reverses a stream of values in full groups of a configurable size
// ----------------------------------------------------------------------------
// usage:
//  - input channel in_valid/in_stall carries value_in and seq_last; a
//    transaction completes when in_valid is high and in_stall is low
//  - output channel out_valid/out_stall carries value_out, out_last and
//    seq_end; the receiver holds out_stall high to pause delivery
//  - group_size is written through cfg_wr_en/cfg_wr_data while idle;
//    zero acts as one, values above MAX_GROUP saturate
//  - each value is stored in the group buffer; when group_size values are
//    held they are sent newest first, and a short group closed by seq_last
//    is sent in arrival order; out_last marks the final result of a step,
//    seq_end the final result of a sequence
//  - input is held off while the buffer's single read port drains a
//    completed group; an item that completes no group causes no hold-off
//  - after the closing transaction the first result passes the buffer
//    read, then the output register; a stalled receiver freezes the drain
//  - reset clears the fill count, the drain state and both output stages
//    and sets group_size to 2; buffer contents are not cleared
// ----------------------------------------------------------------------------
module group_reverse_stream #(
	parameter int MAX_GROUP   = grs_pkg::MAX_GROUP_DEF,
	parameter int VALUE_WIDTH = grs_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_wr_en,
	input  logic [grs_pkg::CFG_WIDTH-1:0] cfg_wr_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [VALUE_WIDTH-1:0] value_in,
	input  logic                          seq_last,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [VALUE_WIDTH-1:0] value_out,
	output logic                          out_last,
	output logic                          seq_end
);

	import grs_pkg::*;

	localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

	logic [CFG_WIDTH-1:0]   group_size_q;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic [VALUE_WIDTH-1:0] rd_data;
	logic [VALUE_WIDTH-1:0] value_out_raw;
	logic                   can_issue;
	rd_issue_t              issue;

	// group size register, write only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= GROUP_SIZE_RESET;
		end else if (cfg_wr_en) begin
			group_size_q <= cfg_wr_data;
		end
	end

	// fill counter and drain sequencer
	grs_ctrl #(
		.MAX_GROUP (MAX_GROUP),
		.AW        (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.seq_last   (seq_last),
		.group_size (group_size_q),
		.can_issue  (can_issue),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.issue      (issue)
	);

	// group buffer; a value written at one edge is readable at the next,
	// so a drain may start right after the closing write
	grs_mem #(
		.DEPTH (MAX_GROUP),
		.WIDTH (VALUE_WIDTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data ($unsigned(value_in)),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// read stage and output register
	grs_outq #(
		.WIDTH (VALUE_WIDTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.can_issue (can_issue),
		.rd_data   (rd_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value_out (value_out_raw),
		.out_last  (out_last),
		.seq_end   (seq_end)
	);

	assign value_out = $signed(value_out_raw);

endmodule

@@ sim/tb_group_reverse_stream.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_group_reverse_stream
// self-checking bench for the group reversing stream block: a table of
// directed transactions and then random sequences under changing group sizes,
// every result checked in order against the table or a predictor in this bench
// ----------------------------------------------------------------------------
module tb_group_reverse_stream;

	localparam int VALUE_WIDTH = grs_pkg::VALUE_WIDTH_DEF;
	localparam int MAX_GROUP   = grs_pkg::MAX_GROUP_DEF;
	localparam int CFG_WIDTH   = grs_pkg::CFG_WIDTH;

	// cycles to let pass before a register write once nothing is expected
	localparam int SETTLE_CYCLES = 6;
	// long receiver hold-off, fills the block and stalls its input
	localparam int HOLD_CYCLES   = 200;
	// cycles without any transaction before the run is declared hung
	localparam int HANG_LIMIT    = 2000;
	// random part: blocks of transactions, one group size per block
	localparam int NUM_BLOCKS    = 8;
	localparam int BLOCK_ITEMS   = 20;
	localparam int NUM_DIRECTED  = 19;

	// one result as it leaves the block
	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] value;
		logic                          last;
		logic                          seq_end;
	} stream_res_t;

	// what the bench knows about an offered transaction: either the
	// predictor decides, or a single typed result (or none) is expected
	typedef struct packed {
		logic        typed;
		logic        has_res;
		stream_res_t res;
	} item_tag_t;

	// one row of the directed table
	typedef struct packed {
		logic                 wr_cfg;
		logic [CFG_WIDTH-1:0] cfg;
		logic [VALUE_WIDTH-1:0] value;
		logic                 last;
		logic                 typed;
		logic                 has_res;
		logic [VALUE_WIDTH-1:0] exp_value;
		logic                 exp_last;
		logic                 exp_end;
	} dir_row_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_wr_en;
	logic [CFG_WIDTH-1:0]          cfg_wr_data;
	logic                          in_valid;
	logic                          in_stall;
	logic signed [VALUE_WIDTH-1:0] value_in;
	logic                          seq_last;
	logic                          out_valid;
	logic                          out_stall;
	logic signed [VALUE_WIDTH-1:0] value_out;
	logic                          out_last;
	logic                          seq_end;

	// predictor state: its own copy of the buffer, fill count and register
	logic [VALUE_WIDTH-1:0] held_values [MAX_GROUP];
	int unsigned            held_count;
	logic [CFG_WIDTH-1:0]   grp_size;

	stream_res_t step_results [$];   // results of the latest accepted item
	stream_res_t reordered_q  [$];   // results still owed by the block
	item_tag_t   item_tag_q   [$];   // tags of offered transactions, in order

	int unsigned mismatches;
	int unsigned snd_idle_pct;
	int unsigned rcv_idle_pct;
	int unsigned hold_reqs;
	int unsigned quiet_cycles;

	// directed table; typed results only where the answer is obvious
	dir_row_t dir_rows [NUM_DIRECTED] = '{
		// reset size 2: first value is held back
		'{1'b0, 5'd0,  32'h7fffffff, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
		// second value completes the pair, sent newest first
		'{1'b0, 5'd0,  32'h80000000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		// lone value closed by the sequence flag
		'{1'b0, 5'd0,  32'h00000000, 1'b1, 1'b1, 1'b1, 32'h00000000, 1'b1, 1'b1},
		// size 1 passes values straight through
		'{1'b1, 5'd1,  32'hffffffff, 1'b0, 1'b1, 1'b1, 32'hffffffff, 1'b1, 1'b0},
		'{1'b0, 5'd0,  32'h00000001, 1'b1, 1'b1, 1'b1, 32'h00000001, 1'b1, 1'b1},
		// size zero acts as one
		'{1'b1, 5'd0,  32'h12345678, 1'b1, 1'b1, 1'b1, 32'h12345678, 1'b1, 1'b1},
		// size 3, full group closing the sequence
		'{1'b1, 5'd3,  32'ha5a5a5a5, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
		'{1'b0, 5'd0,  32'h5a5a5a5a, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
		'{1'b0, 5'd0,  32'h0f0f0f0f, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		// short group at end of sequence keeps arrival order
		'{1'b0, 5'd0,  32'hf0f0f0f0, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
		'{1'b0, 5'd0,  32'h00ff00ff, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		// two values held, then size lowered: all three go out reversed
		'{1'b0, 5'd0,  32'h11111111, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
		'{1'b0, 5'd0,  32'h22222222, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
		'{1'b1, 5'd1,  32'h33333333, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		// size 31 saturates to the buffer depth
		'{1'b1, 5'd31, 32'h80000000, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
		'{1'b0, 5'd0,  32'h7fffffff, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
		'{1'b0, 5'd0,  32'hdeadbeef, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
		'{1'b0, 5'd0,  32'hcafef00d, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		// back to size 2, lone closing value
		'{1'b1, 5'd2,  32'hffffffff, 1'b1, 1'b1, 1'b1, 32'hffffffff, 1'b1, 1'b1}
	};

	// group sizes of the random blocks, extremes among them
	logic [CFG_WIDTH-1:0] block_sizes [NUM_BLOCKS] = '{
		5'd16, 5'd1, 5'd31, 5'd5, 5'd4, 5'd0, 5'd7, 5'd16
	};

	group_reverse_stream DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value_in   (value_in),
		.seq_last   (seq_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value_out  (value_out),
		.out_last   (out_last),
		.seq_end    (seq_end)
	);

	always #5 clk = ~clk;

	// predictor: store the value, then emit a full group newest first, or a
	// short group closed by the sequence flag in arrival order
	task automatic reverse_predict(input logic [VALUE_WIDTH-1:0] v, input logic lst);
		int unsigned k;
		int unsigned n;
		bit          fin;
		stream_res_t r;
		step_results.delete();
		k = grp_size;
		if (k == 0)
			k = 1;
		if (k > MAX_GROUP)
			k = MAX_GROUP;
		if (held_count >= MAX_GROUP)
			held_count = MAX_GROUP - 1;
		held_values[held_count] = v;
		held_count++;
		n = held_count;
		if (n >= k) begin
			for (int i = 0; i < n; i++) begin
				fin = (i + 1 == n);
				r.value = held_values[n - 1 - i];
				r.last = fin;
				r.seq_end = fin && lst;
				step_results = {step_results, r};
			end
			held_count = 0;
		end else if (lst) begin
			for (int i = 0; i < n; i++) begin
				fin = (i + 1 == n);
				r.value = held_values[i];
				r.last = fin;
				r.seq_end = fin;
				step_results = {step_results, r};
			end
			held_count = 0;
		end
	endtask

	// offer one transaction, with random gaps ahead of it; returns at the
	// edge where it is taken
	task automatic offer_value(input logic [VALUE_WIDTH-1:0] v, input logic lst,
		input item_tag_t tag);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value_in <= v;
		seq_last <= lst;
		item_tag_q = {item_tag_q, tag};
		do @(posedge clk); while (in_stall);
	endtask

	// register write, only once the block owes nothing and has settled
	task automatic write_group_size(input logic [CFG_WIDTH-1:0] sz);
		in_valid <= 1'b0;
		do @(posedge clk); while (reordered_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= sz;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		grp_size = sz;
	endtask

	// input side: every accepted transaction runs through the predictor;
	// typed rows replace its answer with the one from the table
	always @(posedge clk) begin : input_mon
		item_tag_t tag;
		if (arst_n && in_valid && !in_stall) begin
			tag = item_tag_q.pop_front();
			reverse_predict(value_in, seq_last);
			if (tag.typed) begin
				if (tag.has_res)
					reordered_q = {reordered_q, tag.res};
			end else begin
				foreach (step_results[i])
					reordered_q = {reordered_q, step_results[i]};
			end
		end
	end

	// output side: each result against the oldest one owed
	always @(posedge clk) begin : output_chk
		stream_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (reordered_q.size() == 0) begin
				mismatches++;
				$error("unexpected result: value_out %h, out_last %b, seq_end %b",
					value_out, out_last, seq_end);
			end else begin
				want = reordered_q.pop_front();
				if (value_out !== want.value) begin
					mismatches++;
					$error("value_out: expected %h, actual %h", want.value, value_out);
				end
				if (out_last !== want.last) begin
					mismatches++;
					$error("out_last: expected %b, actual %b", want.last, out_last);
				end
				if (seq_end !== want.seq_end) begin
					mismatches++;
					$error("seq_end: expected %b, actual %b", want.seq_end, seq_end);
				end
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin : receiver
		int unsigned holds_done;
		holds_done = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_reqs != holds_done) begin
				holds_done = hold_reqs;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
		end
	end

	// hang watchdog: any transaction on either channel counts as progress
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("FAIL group_reverse_stream");
			$finish;
		end
	end

	initial begin : stimulus
		item_tag_t            tag;
		logic [VALUE_WIDTH-1:0] v;
		logic                 lst;
		logic [CFG_WIDTH-1:0] sz;
		int unsigned          last_odds;

		hold_reqs    = 0;
		snd_idle_pct = 19;
		rcv_idle_pct = 47;
		grp_size     = grs_pkg::GROUP_SIZE_RESET;
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		in_valid    <= 1'b0;
		value_in    <= '0;
		seq_last    <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_rows[r]) begin
			if (dir_rows[r].wr_cfg)
				write_group_size(dir_rows[r].cfg);
			tag.typed   = dir_rows[r].typed;
			tag.has_res = dir_rows[r].has_res;
			tag.res     = '{value: dir_rows[r].exp_value, last: dir_rows[r].exp_last,
				seq_end: dir_rows[r].exp_end};
			offer_value(dir_rows[r].value, dir_rows[r].last, tag);
		end

		// random blocks; idling swaps sides after three blocks, then stops
		for (int b = 0; b < NUM_BLOCKS; b++) begin
			if (b == 3) begin
				snd_idle_pct = 47;
				rcv_idle_pct = 19;
			end else if (b == 6) begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			sz = (b == 3) ? CFG_WIDTH'($urandom_range(2, 15)) : block_sizes[b];
			write_group_size(sz);
			// long receiver hold-off while the sender keeps offering
			if (b == 1)
				hold_reqs++;
			// rarer sequence ends for size zero and for large groups, so full groups occur
			last_odds = (sz == 0 || sz >= MAX_GROUP) ? 24 : 7;
			for (int i = 0; i < BLOCK_ITEMS; i++) begin
				case ($urandom_range(0, 9))
					0: v = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
					1: v = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
					2: v = '0;
					3: v = '1;
					default: v = VALUE_WIDTH'($urandom);
				endcase
				lst = ($urandom_range(0, last_odds) == 0);
				tag = '0;
				offer_value(v, lst, tag);
			end
		end

		// drain everything owed, then wait on an idle input for strays
		in_valid <= 1'b0;
		do @(posedge clk); while (reordered_q.size() != 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("PASS group_reverse_stream");
		else
			$display("FAIL group_reverse_stream");
		$finish;
	end

endmodule
